FILE: rtl/core/flh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package flh_pkg;
	localparam int HEAP_BYTES   = 65536;
	localparam int HEADER_BYTES = 16;
	localparam int MAX_SEGMENTS = 2048;

	localparam int GRAN_BYTES = 16;
	localparam int HEAP_GRAN  = HEAP_BYTES / GRAN_BYTES;
	localparam int HDR_GRAN   = (HEADER_BYTES + 15) / GRAN_BYTES;
	localparam int HDR_OFS    = HDR_GRAN * GRAN_BYTES;

	localparam int SEG_AW = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = SEG_AW + 1;
	localparam int GST_W  = $clog2(HEAP_GRAN);
	localparam int GLEN_W = GST_W + 1;

	localparam int REQ_W  = 17;
	localparam int ADDR_W = 16;
	localparam int STAT_W = 17;

	typedef enum logic [1:0] {
		STRAT_BEST  = 2'd0,
		STRAT_FIRST = 2'd1,
		STRAT_NEXT  = 2'd2,
		STRAT_WORST = 2'd3
	} strat_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FAIL = 2'd1,
		ST_NULL = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		logic [GST_W-1:0]  st;
		logic [GLEN_W-1:0] len;
	} seg_ent_t;

	typedef struct packed {
		logic              en;
		logic [SEG_AW-1:0] addr;
		seg_ent_t          data;
	} seg_wr_t;

	typedef struct packed {
		logic              en;
		logic [SEG_AW-1:0] addr;
	} seg_rd_t;

	typedef struct packed {
		logic              en;
		logic [GST_W-1:0]  addr;
		logic [GLEN_W-1:0] data;
	} blk_wr_t;

	typedef struct packed {
		logic             en;
		logic [GST_W-1:0] addr;
	} blk_rd_t;
endpackage
`default_nettype wire

FILE: rtl/core/flh_seg_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module flh_seg_mem import flh_pkg::*; (
	input  wire logic clk,
	input  wire seg_wr_t wr,
	input  wire seg_rd_t rd,
	output seg_ent_t rdata
);
	seg_ent_t mem_q [MAX_SEGMENTS];
	seg_ent_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem_q[rd.addr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/core/flh_blk_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module flh_blk_mem import flh_pkg::*; (
	input  wire logic              clk,
	input  wire blk_wr_t           wr,
	input  wire blk_rd_t           rd,
	output logic [GLEN_W-1:0]      rdata
);
	logic [GLEN_W-1:0] mem_q [HEAP_GRAN];
	logic [GLEN_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem_q[rd.addr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/core/flh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module flh_ctrl import flh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire strat_t            strategy,
	input  wire logic              rover_clr,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire logic [REQ_W-1:0]  request_bytes,
	input  wire logic [ADDR_W-1:0] free_address,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             status,
	output logic [ADDR_W-1:0]      address,
	output logic [CNT_W-1:0]       free_blocks,
	output logic [STAT_W-1:0]      largest_free,
	output logic [STAT_W-1:0]      total_free,
	output seg_wr_t                seg_wr,
	output seg_rd_t                seg_rd,
	input  wire seg_ent_t          seg_rdata,
	output blk_wr_t                blk_wr,
	output blk_rd_t                blk_rd,
	input  wire logic [GLEN_W-1:0] blk_rdata
);
	typedef enum logic [12:0] {
		S_INIT    = 13'b0000000000001,
		S_IDLE    = 13'b0000000000010,
		S_AL_SCAN = 13'b0000000000100,
		S_AL_DEC  = 13'b0000000001000,
		S_FR_RD   = 13'b0000000010000,
		S_FR_CHK  = 13'b0000000100000,
		S_FR_SCAN = 13'b0000001000000,
		S_FR_DEC  = 13'b0000010000000,
		S_SHIFT   = 13'b0000100000000,
		S_INS     = 13'b0001000000000,
		S_STAT_GO = 13'b0010000000000,
		S_STAT    = 13'b0100000000000,
		S_DONE    = 13'b1000000000000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0]  count_q;
	logic [SEG_AW-1:0] rover_q;
	logic [GLEN_W-1:0] total_q;

	// read stream
	logic [SEG_AW-1:0] r_q;
	logic [CNT_W-1:0]  rem_q;
	logic              dir_q;
	logic              wrap_q;
	logic              rd_v_s1;
	logic [SEG_AW-1:0] rd_idx_s1;

	logic [GLEN_W-1:0] need_q;
	logic [GST_W-1:0]  s_q;
	logic [GLEN_W-1:0] blen_q;
	logic              found_q;
	logic [SEG_AW-1:0] pidx_q;
	logic [GST_W-1:0]  pst_q;
	logic [GLEN_W-1:0] plen_q;
	logic              hasp_q, hasn_q;
	logic [GST_W-1:0]  pvst_q, nxst_q;
	logic [GLEN_W-1:0] pvln_q, nxln_q;
	logic [CNT_W-1:0]  p_q;
	logic              ins_q;
	logic [GLEN_W-1:0] lg_q;
	logic [1:0]        res_status_q;
	logic [ADDR_W-1:0] res_addr_q;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [GLEN_W-1:0] out_lg_q, out_tot_q;

	logic              in_acc, issue, scan_end;
	logic [SEG_AW-1:0] r_nx, base;
	logic [13:0]       need14;
	logic              too_large, fa_bad;
	logic              fit, better, take;
	logic              al_exact, al_fail;
	logic [REQ_W-1:0]  al_ofs;
	logic [13:0]       pv_end, s_end;
	logic              mprev, mnext, ovp, ovn, full, fr_fail;
	logic              blen_bad;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign issue    = (rem_q != '0) &&
		(state_q == S_AL_SCAN || state_q == S_FR_SCAN || state_q == S_SHIFT
		|| state_q == S_STAT);
	assign scan_end = (rem_q == '0) && !rd_v_s1;

	always_comb begin
		if (dir_q) begin
			if (wrap_q && (CNT_W'(r_q) + CNT_W'(1)) == count_q) begin
				r_nx = '0;
			end else begin
				r_nx = r_q + SEG_AW'(1);
			end
		end else begin
			r_nx = r_q - SEG_AW'(1);
		end
	end

	assign base = (strategy == STRAT_NEXT && CNT_W'(rover_q) < count_q) ? rover_q : '0;
	assign need14 = 14'(HDR_GRAN) + 14'((18'(request_bytes) + 18'd15) >> 4);
	assign too_large = need14 > 14'(HEAP_GRAN);
	assign fa_bad = (free_address < ADDR_W'(HDR_OFS)) || (free_address[3:0] != 4'd0);

	assign fit    = seg_rdata.len >= need_q;
	assign better = !found_q
		|| (strategy == STRAT_BEST && seg_rdata.len < plen_q)
		|| (strategy == STRAT_WORST && seg_rdata.len > plen_q);
	assign take   = fit && better;

	assign al_exact = (plen_q == need_q);
	assign al_ofs   = {1'b0, pst_q, 4'd0} + REQ_W'(HDR_OFS);
	assign al_fail  = !found_q || al_ofs[REQ_W-1];

	assign pv_end  = 14'(pvst_q) + 14'(pvln_q);
	assign s_end   = 14'(s_q) + 14'(blen_q);
	assign mprev   = hasp_q && pv_end == 14'(s_q);
	assign ovp     = hasp_q && pv_end > 14'(s_q);
	assign mnext   = hasn_q && s_end == 14'(nxst_q);
	assign ovn     = hasn_q && s_end > 14'(nxst_q);
	assign full    = !mprev && !mnext && count_q >= CNT_W'(MAX_SEGMENTS);
	assign fr_fail = ovp || ovn || full;

	assign blen_bad = (blk_rdata == '0) ||
		(blk_rdata > GLEN_W'(HEAP_GRAN) - GLEN_W'(s_q));

	always_comb begin
		seg_wr = '0;
		blk_wr = '0;
		seg_rd.en   = issue;
		seg_rd.addr = r_q;
		blk_rd.en   = (state_q == S_FR_RD);
		blk_rd.addr = s_q;
		case (state_q)
			S_INIT: begin
				seg_wr.en       = 1'b1;
				seg_wr.addr     = '0;
				seg_wr.data.st  = '0;
				seg_wr.data.len = GLEN_W'(HEAP_GRAN);
			end
			S_AL_DEC: begin
				if (!al_fail) begin
					blk_wr.en   = 1'b1;
					blk_wr.addr = pst_q;
					blk_wr.data = need_q;
					if (!al_exact) begin
						seg_wr.en       = 1'b1;
						seg_wr.addr     = pidx_q;
						seg_wr.data.st  = GST_W'(GLEN_W'(pst_q) + need_q);
						seg_wr.data.len = plen_q - need_q;
					end
				end
			end
			S_FR_DEC: begin
				if (!fr_fail) begin
					blk_wr.en   = 1'b1;
					blk_wr.addr = s_q;
					blk_wr.data = '0;
					if (mprev) begin
						seg_wr.en      = 1'b1;
						seg_wr.addr    = SEG_AW'(p_q - CNT_W'(1));
						seg_wr.data.st = pvst_q;
						seg_wr.data.len = mnext ? pvln_q + blen_q + nxln_q : pvln_q + blen_q;
					end else if (mnext) begin
						seg_wr.en       = 1'b1;
						seg_wr.addr     = SEG_AW'(p_q);
						seg_wr.data.st  = s_q;
						seg_wr.data.len = nxln_q + blen_q;
					end
				end
			end
			S_SHIFT: begin
				if (rd_v_s1) begin
					seg_wr.en   = 1'b1;
					seg_wr.addr = dir_q ? rd_idx_s1 - SEG_AW'(1) : rd_idx_s1 + SEG_AW'(1);
					seg_wr.data = seg_rdata;
				end
			end
			S_INS: begin
				seg_wr.en       = 1'b1;
				seg_wr.addr     = SEG_AW'(p_q);
				seg_wr.data.st  = s_q;
				seg_wr.data.len = blen_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			count_q     <= CNT_W'(1);
			rover_q     <= '0;
			total_q     <= GLEN_W'(HEAP_GRAN);
			rem_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1   <= issue;
			rd_idx_s1 <= r_q;
			if (issue) begin
				rem_q <= rem_q - CNT_W'(1);
				r_q   <= r_nx;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rover_clr) begin
				rover_q <= '0;
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						res_addr_q <= '0;
						if (op == OP_ALLOC) begin
							need_q <= GLEN_W'(need14);
							if (too_large) begin
								res_status_q <= ST_FAIL;
								state_q      <= S_STAT_GO;
							end else begin
								found_q <= 1'b0;
								rem_q   <= count_q;
								r_q     <= base;
								dir_q   <= 1'b1;
								wrap_q  <= 1'b1;
								state_q <= S_AL_SCAN;
							end
						end else begin
							s_q <= GST_W'((free_address - ADDR_W'(HDR_OFS)) >> 4);
							if (free_address == '0) begin
								res_status_q <= ST_NULL;
								state_q      <= S_STAT_GO;
							end else if (fa_bad) begin
								res_status_q <= ST_FAIL;
								state_q      <= S_STAT_GO;
							end else begin
								state_q <= S_FR_RD;
							end
						end
					end
				end
				S_AL_SCAN: begin
					if (rd_v_s1 && take) begin
						found_q <= 1'b1;
						pidx_q  <= rd_idx_s1;
						pst_q   <= seg_rdata.st;
						plen_q  <= seg_rdata.len;
					end
					if (scan_end) begin
						state_q <= S_AL_DEC;
					end
				end
				S_AL_DEC: begin
					if (al_fail) begin
						res_status_q <= ST_FAIL;
						state_q      <= S_STAT_GO;
					end else begin
						res_status_q <= ST_DONE;
						res_addr_q   <= al_ofs[ADDR_W-1:0];
						total_q      <= total_q - need_q;
						if (al_exact) begin
							count_q <= count_q - CNT_W'(1);
							if (strategy == STRAT_NEXT) begin
								rover_q <= (CNT_W'(pidx_q) < count_q - CNT_W'(1)) ? pidx_q : '0;
							end
							rem_q   <= count_q - CNT_W'(1) - CNT_W'(pidx_q);
							r_q     <= pidx_q + SEG_AW'(1);
							dir_q   <= 1'b1;
							wrap_q  <= 1'b0;
							ins_q   <= 1'b0;
							state_q <= S_SHIFT;
						end else begin
							if (strategy == STRAT_NEXT) begin
								rover_q <= pidx_q;
							end
							state_q <= S_STAT_GO;
						end
					end
				end
				S_FR_RD: begin
					state_q <= S_FR_CHK;
				end
				S_FR_CHK: begin
					blen_q <= blk_rdata;
					if (blen_bad) begin
						res_status_q <= ST_FAIL;
						state_q      <= S_STAT_GO;
					end else begin
						hasp_q  <= 1'b0;
						hasn_q  <= 1'b0;
						p_q     <= '0;
						rem_q   <= count_q;
						r_q     <= '0;
						dir_q   <= 1'b1;
						wrap_q  <= 1'b0;
						state_q <= S_FR_SCAN;
					end
				end
				S_FR_SCAN: begin
					if (rd_v_s1) begin
						if (seg_rdata.st < s_q) begin
							hasp_q <= 1'b1;
							pvst_q <= seg_rdata.st;
							pvln_q <= seg_rdata.len;
							p_q    <= CNT_W'(rd_idx_s1) + CNT_W'(1);
						end else if (!hasn_q) begin
							hasn_q <= 1'b1;
							nxst_q <= seg_rdata.st;
							nxln_q <= seg_rdata.len;
						end
					end
					if (scan_end) begin
						state_q <= S_FR_DEC;
					end
				end
				S_FR_DEC: begin
					if (fr_fail) begin
						res_status_q <= ST_FAIL;
						state_q      <= S_STAT_GO;
					end else begin
						res_status_q <= ST_DONE;
						total_q      <= total_q + blen_q;
						if (strategy == STRAT_NEXT) begin
							rover_q <= mprev ? SEG_AW'(p_q - CNT_W'(1)) : SEG_AW'(p_q);
						end
						if (mprev && mnext) begin
							count_q <= count_q - CNT_W'(1);
							rem_q   <= count_q - CNT_W'(1) - p_q;
							r_q     <= SEG_AW'(p_q + CNT_W'(1));
							dir_q   <= 1'b1;
							wrap_q  <= 1'b0;
							ins_q   <= 1'b0;
							state_q <= S_SHIFT;
						end else if (mprev || mnext) begin
							state_q <= S_STAT_GO;
						end else begin
							count_q <= count_q + CNT_W'(1);
							rem_q   <= count_q - p_q;
							r_q     <= SEG_AW'(count_q - CNT_W'(1));
							dir_q   <= 1'b0;
							wrap_q  <= 1'b0;
							ins_q   <= 1'b1;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (scan_end) begin
						state_q <= ins_q ? S_INS : S_STAT_GO;
					end
				end
				S_INS: begin
					state_q <= S_STAT_GO;
				end
				S_STAT_GO: begin
					lg_q    <= '0;
					rem_q   <= count_q;
					r_q     <= '0;
					dir_q   <= 1'b1;
					wrap_q  <= 1'b0;
					state_q <= S_STAT;
				end
				S_STAT: begin
					if (rd_v_s1 && seg_rdata.len > lg_q) begin
						lg_q <= seg_rdata.len;
					end
					if (scan_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						out_cnt_q    <= count_q;
						out_lg_q     <= lg_q;
						out_tot_q    <= total_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign address      = out_addr_q;
	assign free_blocks  = out_cnt_q;
	assign largest_free = {out_lg_q, 4'd0};
	assign total_free   = {out_tot_q, 4'd0};

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SEGMENTS))
		else $error("segment count above table depth");
	a_total_max: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= GLEN_W'(HEAP_GRAN))
		else $error("free total above heap size");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> rem_q == '0 && !rd_v_s1)
		else $error("reads in flight while idle");
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("idle right after accepting a beat");
endmodule
`default_nettype wire

FILE: rtl/core/free_list_heap_allocator_top.sv
// a rejected beat skips the table shift before the statistics sweep and the result beat
// throughput: one item at a time; the free segment table memory (one read, one write
// port) is swept for the fit or neighbor search, the table shift and the statistics
// reset: asynchronous, active low; the init state entered on reset writes the single whole-heap
// segment into table entry zero, the allocation length table is left as is
`timescale 1ns / 1ps
`default_nettype none
module free_list_heap_allocator_top import flh_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // request_bytes, free_address
	input  wire logic [0:0]  s_tuser,  // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // address, free_blocks, largest_free, total_free
	output logic [1:0]       m_tuser   // status
);
	strat_t            strategy_q;
	logic              cfg_we;
	seg_wr_t           seg_wr;
	seg_rd_t           seg_rd;
	seg_ent_t          seg_rdata;
	blk_wr_t           blk_wr;
	blk_rd_t           blk_rd;
	logic [GLEN_W-1:0] blk_rdata;
	logic [1:0]        status;
	logic [ADDR_W-1:0] address;
	logic [CNT_W-1:0]  free_blocks;
	logic [STAT_W-1:0] largest_free, total_free;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {30'd0, strategy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= STRAT_BEST;
		end else if (cfg_we) begin
			strategy_q <= strat_t'(pwdata[1:0]);
		end
	end

	flh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.strategy      (strategy_q),
		.rover_clr     (cfg_we && pwdata[1:0] == STRAT_NEXT),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.op            (s_tuser[0]),
		.request_bytes (s_tdata[16:0]),
		.free_address  (s_tdata[32:17]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.status        (status),
		.address       (address),
		.free_blocks   (free_blocks),
		.largest_free  (largest_free),
		.total_free    (total_free),
		.seg_wr        (seg_wr),
		.seg_rd        (seg_rd),
		.seg_rdata     (seg_rdata),
		.blk_wr        (blk_wr),
		.blk_rd        (blk_rd),
		.blk_rdata     (blk_rdata)
	);

	flh_seg_mem u_seg_mem (
		.clk   (clk),
		.wr    (seg_wr),
		.rd    (seg_rd),
		.rdata (seg_rdata)
	);

	flh_blk_mem u_blk_mem (
		.clk   (clk),
		.wr    (blk_wr),
		.rd    (blk_rd),
		.rdata (blk_rdata)
	);

	assign m_tuser = status;
	assign m_tdata = {2'd0, total_free, largest_free, free_blocks, address};
endmodule
`default_nettype wire

FILE: bench/tb_free_list_heap_allocator_top.sv
`timescale 1ns / 1ps
module tb_free_list_heap_allocator_top;
	import flh_pkg::*;

	localparam int LIMIT_CYCLES = 20000000;
	localparam int N_RANDOM     = 1880;

	typedef struct packed {
		status_t     status;
		logic [15:0] address;
		logic [11:0] free_blocks;
		logic [16:0] largest_free;
		logic [16:0] total_free;
	} alloc_result_t;

	typedef struct {
		op_t         op;
		logic [16:0] req;
		logic [15:0] fa;
		logic        typed;
		status_t     status;
		logic [15:0] address;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	free_list_heap_allocator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// shadow allocator state
	int unsigned seg_start[MAX_SEGMENTS];
	int unsigned seg_len[MAX_SEGMENTS];
	int unsigned seg_cnt;
	int unsigned rover;
	int unsigned blk_len[HEAP_GRAN];
	bit          blk_written[HEAP_GRAN];
	strat_t      cur_strat;

	alloc_result_t pending_results[$];
	logic [15:0]   live_blocks[$];
	int unsigned   errors;
	int unsigned   n_results;
	int unsigned   n_alloc_ok, n_free_ok, n_fail;
	longint        cycle;
	bit            hold_off;
	bit            no_idle;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT_CYCLES) begin
			$display("%0t timeout", $time);
			$display("tb_free_list_heap_allocator_top: errors");
			$finish;
		end
	end

	function automatic void shadow_reset();
		seg_start[0] = 0;
		seg_len[0] = HEAP_GRAN;
		seg_cnt = 1;
		rover = 0;
		cur_strat = STRAT_BEST;
		for (int g = 0; g < HEAP_GRAN; g++) begin
			blk_len[g] = 0;
			blk_written[g] = 1'b0;
		end
	endfunction

	function automatic void seg_remove(int unsigned i);
		for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
			seg_start[k] = seg_start[k+1];
			seg_len[k] = seg_len[k+1];
		end
		seg_cnt--;
	endfunction

	function automatic void seg_insert(int unsigned i, int unsigned s, int unsigned len);
		for (int unsigned k = seg_cnt; k > i; k--) begin
			seg_start[k] = seg_start[k-1];
			seg_len[k] = seg_len[k-1];
		end
		seg_start[i] = s;
		seg_len[i] = len;
		seg_cnt++;
	endfunction

	function automatic int pick_segment(int unsigned need);
		int pick;
		int unsigned first, j;
		pick = -1;
		if (seg_cnt == 0)
			return -1;
		if (cur_strat == STRAT_NEXT) begin
			first = (rover < seg_cnt) ? rover : 0;
			for (int unsigned i = 0; i < seg_cnt; i++) begin
				j = (first + i) % seg_cnt;
				if (seg_len[j] >= need)
					return j;
			end
			return -1;
		end
		for (int unsigned i = 0; i < seg_cnt; i++) begin
			if (seg_len[i] < need)
				continue;
			if (cur_strat == STRAT_FIRST)
				return i;
			if (pick < 0 || (cur_strat == STRAT_BEST && seg_len[i] < seg_len[pick]) ||
					(cur_strat == STRAT_WORST && seg_len[i] > seg_len[pick]))
				pick = i;
		end
		return pick;
	endfunction

	function automatic status_t place_block(int unsigned req, output logic [15:0] addr);
		int unsigned need, i, g, ofs;
		int pick;
		addr = '0;
		need = HDR_GRAN + ((req + 15) >> 4);
		if (need * GRAN_BYTES > HEAP_BYTES)
			return ST_FAIL;
		pick = pick_segment(need);
		if (pick < 0)
			return ST_FAIL;
		i = pick;
		g = seg_start[i];
		ofs = g * GRAN_BYTES + HDR_OFS;
		if (ofs > 16'hFFFF || g >= HEAP_GRAN)
			return ST_FAIL;
		if (seg_len[i] == need) begin
			seg_remove(i);
			if (cur_strat == STRAT_NEXT)
				rover = (i < seg_cnt) ? i : 0;
		end else begin
			seg_start[i] += need;
			seg_len[i] -= need;
			if (cur_strat == STRAT_NEXT)
				rover = i;
		end
		blk_len[g] = need;
		blk_written[g] = 1'b1;
		addr = ofs[15:0];
		return ST_DONE;
	endfunction

	function automatic status_t release_block(int unsigned fa);
		int unsigned s, len, p, idx;
		bit mprev, mnext;
		if (fa == 0)
			return ST_NULL;
		if (fa < HDR_OFS || ((fa - HDR_OFS) & 15) != 0)
			return ST_FAIL;
		s = (fa - HDR_OFS) >> 4;
		if (s >= HEAP_GRAN)
			return ST_FAIL;
		len = blk_len[s];
		if (len == 0 || len > HEAP_GRAN - s)
			return ST_FAIL;
		p = 0;
		while (p < seg_cnt && seg_start[p] < s)
			p++;
		if (p > 0 && seg_start[p-1] + seg_len[p-1] > s)
			return ST_FAIL;
		if (p < seg_cnt && s + len > seg_start[p])
			return ST_FAIL;
		mprev = p > 0 && seg_start[p-1] + seg_len[p-1] == s;
		mnext = p < seg_cnt && s + len == seg_start[p];
		if (!mprev && !mnext && seg_cnt >= MAX_SEGMENTS)
			return ST_FAIL;
		if (mprev && mnext) begin
			seg_len[p-1] += len + seg_len[p];
			seg_remove(p);
			idx = p - 1;
		end else if (mprev) begin
			seg_len[p-1] += len;
			idx = p - 1;
		end else if (mnext) begin
			seg_start[p] = s;
			seg_len[p] += len;
			idx = p;
		end else begin
			seg_insert(p, s, len);
			idx = p;
		end
		blk_len[s] = 0;
		if (cur_strat == STRAT_NEXT)
			rover = idx;
		return ST_DONE;
	endfunction

	function automatic alloc_result_t predict_heap_step(op_t op, int unsigned req,
			int unsigned fa);
		alloc_result_t r;
		logic [15:0] a;
		int unsigned big, sum, b;
		a = '0;
		if (op == OP_ALLOC)
			r.status = place_block(req, a);
		else
			r.status = release_block(fa);
		big = 0;
		sum = 0;
		for (int unsigned i = 0; i < seg_cnt; i++) begin
			b = seg_len[i] * GRAN_BYTES;
			sum += b;
			if (b > big)
				big = b;
		end
		r.address = a;
		r.free_blocks = seg_cnt[11:0];
		r.largest_free = big[16:0];
		r.total_free = sum[16:0];
		return r;
	endfunction

	// a free is legal stimulus if null, malformed or its start granule was written
	function automatic bit free_allowed(int unsigned fa);
		if (fa == 0 || fa < HDR_OFS || ((fa - HDR_OFS) & 15) != 0)
			return 1'b1;
		if (((fa - HDR_OFS) >> 4) >= HEAP_GRAN)
			return 1'b1;
		return blk_written[(fa - HDR_OFS) >> 4];
	endfunction

	// tvalid stays up after a beat until the next beat or an idle stretch replaces it
	task automatic send_beat(op_t op, logic [16:0] req, logic [15:0] fa, bit typed,
			status_t t_status, logic [15:0] t_addr);
		alloc_result_t r;
		int unsigned gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'b0, fa, req};
		do
			@(posedge clk);
		while (!s_tready);
		r = predict_heap_step(op, req, fa);
		if (typed && (r.status !== t_status || r.address !== t_addr)) begin
			$display("%0t table row mismatch: expected status %0d addr %h, got %0d %h",
				$time, t_status, t_addr, r.status, r.address);
			errors++;
		end
		if (r.status == ST_DONE && op == OP_ALLOC)
			live_blocks.push_back(r.address);
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (3 * MAX_SEGMENTS + 40) @(negedge clk);
	endtask

	task automatic apb_write_strategy(strat_t s);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {30'b0, s};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		cur_strat = s;
		if (s == STRAT_NEXT)
			rover = 0;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t e;
		alloc_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tuser);
			got.address = m_tdata[15:0];
			got.free_blocks = m_tdata[27:16];
			got.largest_free = m_tdata[44:28];
			got.total_free = m_tdata[61:45];
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected beat: expected none, actual %h", $time, got);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (got.status != e.status || got.address != e.address ||
						got.free_blocks != e.free_blocks ||
						got.largest_free != e.largest_free ||
						got.total_free != e.total_free) begin
					$display("%0t mismatch: expected %0d/%h/%0d/%0d/%0d actual %0d/%h/%0d/%0d/%0d",
						$time, e.status, e.address, e.free_blocks, e.largest_free,
						e.total_free, got.status, got.address, got.free_blocks,
						got.largest_free, got.total_free);
					errors++;
				end
				if (e.status == ST_DONE && e.address != 0)
					n_alloc_ok++;
				else if (e.status == ST_DONE)
					n_free_ok++;
				else if (e.status == ST_FAIL)
					n_fail++;
			end
		end
	end

	// receiver stalls
	initial begin
		int unsigned gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 11);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	stim_row_t rows[$];

	function automatic void add_row(op_t op, int unsigned req, int unsigned fa,
			bit typed = 0, status_t st = ST_DONE, int unsigned a = 0);
		stim_row_t r;
		r.op = op;
		r.req = req[16:0];
		r.fa = fa[15:0];
		r.typed = typed;
		r.status = st;
		r.address = a[15:0];
		rows.push_back(r);
	endfunction

	task automatic random_item(int unsigned mix);
		op_t op;
		int unsigned req, fa, k;
		if ($urandom_range(0, 99) < mix) begin
			op = OP_ALLOC;
			case ($urandom_range(0, 9))
				0: req = $urandom_range(0, 131071);
				1: req = $urandom_range(4096, 65536);
				default: req = $urandom_range(0, 700);
			endcase
			fa = $urandom_range(0, 65535);
		end else begin
			op = OP_FREE;
			req = $urandom_range(0, 131071);
			k = $urandom_range(0, 19);
			if (k < 15 && live_blocks.size() != 0) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				fa = live_blocks[k];
				live_blocks.delete(k);
			end else begin
				do
					fa = $urandom_range(0, 65535);
				while (!free_allowed(fa));
			end
		end
		send_beat(op, req[16:0], fa[15:0], 1'b0, ST_DONE, '0);
	endtask

	initial begin
		int unsigned sent;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		errors = 0;
		n_results = 0;
		n_alloc_ok = 0;
		n_free_ok = 0;
		n_fail = 0;
		cycle = 0;
		hold_off = 1'b0;
		no_idle = 1'b0;
		shadow_reset();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(negedge clk);

		add_row(OP_FREE, 0, 0, 1, ST_NULL, 0);
		add_row(OP_ALLOC, 0, 0, 1, ST_DONE, 16'h0010);
		add_row(OP_ALLOC, 1, 0, 1, ST_DONE, 16'h0020);
		add_row(OP_ALLOC, 65536, 0, 1, ST_FAIL, 0);
		add_row(OP_ALLOC, 131071, 0, 1, ST_FAIL, 0);
		add_row(OP_FREE, 0, 16'h0008, 1, ST_FAIL, 0);
		add_row(OP_FREE, 0, 16'h0018, 1, ST_FAIL, 0);
		add_row(OP_FREE, 0, 16'h0010, 1, ST_DONE, 0);
		add_row(OP_FREE, 0, 16'h0010, 1, ST_FAIL, 0);
		add_row(OP_ALLOC, 17, 0);
		add_row(OP_ALLOC, 100, 0);
		add_row(OP_ALLOC, 32, 0);
		add_row(OP_FREE, 131071, 16'h0020);
		add_row(OP_FREE, 0, 16'h0070);
		add_row(OP_ALLOC, 65520 - 400, 0);
		add_row(OP_ALLOC, 65520, 0, 1, ST_FAIL, 0);
		add_row(OP_FREE, 0, 16'hFFFF, 1, ST_FAIL, 0);
		foreach (rows[i])
			send_beat(rows[i].op, rows[i].req, rows[i].fa, rows[i].typed,
				rows[i].status, rows[i].address);
		wait_drain();

		sent = 0;
		for (int ph = 0; ph < 8; ph++) begin
			apb_write_strategy(strat_t'(ph % 4));
			if (ph == 2) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (4000) @(negedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			if (ph == 7)
				no_idle = 1'b1;
			for (int n = 0; n < N_RANDOM / 8; n++) begin
				random_item((n % 200) < 120 ? 75 : 35);
				sent++;
			end
			wait_drain();
		end

		$display("ran %0d random items over all four placement policies", sent);
		$display("%0d allocations, %0d frees, %0d rejects, %0d beats checked",
			n_alloc_ok, n_free_ok, n_fail, n_results);
		if (errors == 0)
			$display("tb_free_list_heap_allocator_top: clean");
		else
			$display("tb_free_list_heap_allocator_top: errors");
		$finish;
	end
endmodule

FILE: free_list_heap_allocator_top.f
rtl/core/flh_pkg.sv
rtl/core/flh_seg_mem.sv
rtl/core/flh_blk_mem.sv
rtl/core/flh_ctrl.sv
rtl/core/free_list_heap_allocator_top.sv
bench/tb_free_list_heap_allocator_top.sv
